[hw/rtl/tlrq_pkg.sv]
package tlrq_pkg;

    localparam int LEVEL_DEPTH_DEF = 64;
    localparam int ID_BITS_DEF     = 16;
    localparam int NUM_LEVELS      = 3;

    localparam logic [7:0] PRIO_TOP_HIGH = 8'd149;
    localparam logic [7:0] PRIO_TOP_LOW  = 8'd100;
    localparam logic [7:0] PRIO_MID_HIGH = 8'd99;
    localparam logic [7:0] PRIO_MID_LOW  = 8'd50;
    localparam logic [7:0] PRIO_RR_HIGH  = 8'd49;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] LVL_TOP = 2'd0;
    localparam logic [1:0] LVL_MID = 2'd1;
    localparam logic [1:0] LVL_RR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [15:0] task_id;
        logic [7:0]  task_priority;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_task_id;
        logic [7:0]  out_priority;
        logic [1:0]  out_level;
    } t_out;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_POP    = 2'd1,
        K_INSERT = 2'd2
    } t_kind;

    typedef struct packed {
        logic accept;
        logic simple;
        logic rd_head;
        logic pop_fin;
        logic mid_start;
        logic mid_step;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  step_done;
    } t_stat;

endpackage

[hw/rtl/tlrq_datapath.sv]
module tlrq_datapath
    import tlrq_pkg::*;
#(
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_in   i_item,
    output t_stat o_stat,
    output t_out  o_res
);

    localparam int IW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW = $clog2(LEVEL_DEPTH + 1);
    localparam int EW = ID_BITS + 8;

    t_in               r_item;
    logic [1:0]        r_lvl;
    logic [CW-1:0]     r_cnt  [NUM_LEVELS];
    logic [IW-1:0]     r_head [NUM_LEVELS];
    logic [IW-1:0]     r_hole;
    t_out              r_res;
    logic [EW-1:0]     r_rdata [NUM_LEVELS];
    logic [EW-1:0]     r_mem [NUM_LEVELS][LEVEL_DEPTH];

    logic [EW-1:0]     item_entry;
    logic [1:0]        push_lvl;
    logic [1:0]        pop_lvl;
    logic              is_pop;
    logic              out_of_range;
    logic              pop_empty;
    logic              level_full;
    logic              push_ok;
    t_out              simple_res;
    logic [EW-1:0]     mid_rdata;
    logic [EW-1:0]     pop_rdata;
    logic              item_before;
    logic              step_done;
    logic [NUM_LEVELS-1:0] we;
    logic [NUM_LEVELS-1:0] re;
    logic [IW-1:0]     waddr;
    logic [IW-1:0]     raddr;
    logic [EW-1:0]     wdata;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
        logic [IW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IW+1)'(LEVEL_DEPTH)) begin
            s = s - (IW+1)'(LEVEL_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    assign item_entry   = {ID_BITS'(r_item.task_id), r_item.task_priority};
    assign is_pop       = (r_item.operation == OP_POP);
    assign out_of_range = (r_item.task_priority > PRIO_TOP_HIGH);

    always_comb begin
        if (r_item.task_priority >= PRIO_TOP_LOW) begin
            push_lvl = LVL_TOP;
        end else if (r_item.task_priority >= PRIO_MID_LOW) begin
            push_lvl = LVL_MID;
        end else begin
            push_lvl = LVL_RR;
        end
        if (r_cnt[LVL_TOP] != '0) begin
            pop_lvl = LVL_TOP;
        end else if (r_cnt[LVL_MID] != '0) begin
            pop_lvl = LVL_MID;
        end else begin
            pop_lvl = LVL_RR;
        end
    end

    assign pop_empty  = (r_cnt[LVL_TOP] == '0) && (r_cnt[LVL_MID] == '0) &&
                        (r_cnt[LVL_RR] == '0);
    assign level_full = (r_cnt[push_lvl] == CW'(LEVEL_DEPTH));
    assign push_ok    = !is_pop && !out_of_range && !level_full;

    always_comb begin
        simple_res = '0;
        if (is_pop) begin
            simple_res.status = ST_EMPTY;
        end else if (out_of_range) begin
            simple_res.status = ST_RANGE;
        end else begin
            simple_res.status    = level_full ? ST_FULL : ST_OK;
            simple_res.out_level = push_lvl;
        end
    end

    always_comb begin
        if (is_pop) begin
            o_stat.kind = pop_empty ? K_SIMPLE : K_POP;
        end else if (push_ok && (push_lvl == LVL_MID) && (r_cnt[LVL_MID] != '0)) begin
            o_stat.kind = K_INSERT;
        end else begin
            o_stat.kind = K_SIMPLE;
        end
    end

    assign mid_rdata   = r_rdata[LVL_MID];
    assign pop_rdata   = r_rdata[r_lvl];
    assign item_before = (r_item.task_priority > mid_rdata[7:0]) ||
                         ((r_item.task_priority == mid_rdata[7:0]) &&
                          (ID_BITS'(r_item.task_id) < mid_rdata[EW-1:8]));
    assign step_done   = (r_hole == '0) || !item_before;
    assign o_stat.step_done = step_done;

    always_comb begin
        we    = '0;
        re    = '0;
        waddr = wrap_add(r_head[push_lvl], r_cnt[push_lvl][IW-1:0]);
        raddr = r_head[pop_lvl];
        wdata = item_entry;
        if (i_cmd.simple && push_ok) begin
            we[push_lvl] = 1'b1;
        end
        if (i_cmd.rd_head) begin
            re[pop_lvl] = 1'b1;
        end
        if (i_cmd.mid_start) begin
            re[LVL_MID] = 1'b1;
            raddr = wrap_add(r_head[LVL_MID], r_cnt[LVL_MID][IW-1:0] - IW'(1));
        end
        if (i_cmd.mid_step) begin
            we[LVL_MID] = 1'b1;
            waddr = wrap_add(r_head[LVL_MID], r_hole);
            if (!step_done) begin
                wdata = mid_rdata;
                if (r_hole > IW'(1)) begin
                    re[LVL_MID] = 1'b1;
                    raddr = wrap_add(r_head[LVL_MID], r_hole - IW'(2));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (we[l]) begin
                r_mem[l][waddr] <= wdata;
            end
            if (re[l]) begin
                r_rdata[l] <= r_mem[l][raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        if (i_cmd.simple) begin
            r_res <= simple_res;
        end
        if (i_cmd.rd_head) begin
            r_lvl <= pop_lvl;
        end
        if (i_cmd.pop_fin) begin
            r_res.status       <= ST_OK;
            r_res.out_task_id  <= 16'(pop_rdata[EW-1:8]);
            r_res.out_priority <= pop_rdata[7:0];
            r_res.out_level    <= r_lvl;
        end
        if (i_cmd.mid_start) begin
            r_hole <= r_cnt[LVL_MID][IW-1:0];
        end
        if (i_cmd.mid_step) begin
            if (step_done) begin
                r_res <= '{status: ST_OK, out_task_id: '0, out_priority: '0,
                           out_level: LVL_MID};
            end else begin
                r_hole <= r_hole - IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_cnt[l]  <= '0;
                r_head[l] <= '0;
            end
        end else begin
            if (i_cmd.simple && push_ok) begin
                r_cnt[push_lvl] <= r_cnt[push_lvl] + CW'(1);
            end
            if (i_cmd.mid_step && step_done) begin
                r_cnt[LVL_MID] <= r_cnt[LVL_MID] + CW'(1);
            end
            if (i_cmd.pop_fin) begin
                r_cnt[r_lvl]  <= r_cnt[r_lvl] - CW'(1);
                r_head[r_lvl] <= wrap_add(r_head[r_lvl], IW'(1));
            end
        end
    end

    assign o_res = r_res;

endmodule

[hw/rtl/tlrq_ctrl.sv]
module tlrq_ctrl
    import tlrq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_POP_FIN  = 5'b00100,
        S_INS_STEP = 5'b01000,
        S_OUT      = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.kind)
                    K_POP: begin
                        o_cmd.rd_head = 1'b1;
                        n_state       = S_POP_FIN;
                    end
                    K_INSERT: begin
                        o_cmd.mid_start = 1'b1;
                        n_state         = S_INS_STEP;
                    end
                    default: begin
                        o_cmd.simple = 1'b1;
                        n_state      = S_OUT;
                    end
                endcase
            end
            S_POP_FIN: begin
                o_cmd.pop_fin = 1'b1;
                n_state       = S_OUT;
            end
            S_INS_STEP: begin
                o_cmd.mid_step = 1'b1;
                if (i_stat.step_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

endmodule

[hw/rtl/three_level_ready_queue.sv]
// Three-level scheduler ready queue: a push files a task into the top level (priority 100 to
// 149, FIFO), the middle level (50 to 99, kept sorted by higher priority, then smaller id) or
// the round-robin FIFO (0 to 49); a pop serves top, then middle, then round robin. One item is
// handled at a time, from its input transfer through its result transfer. A pop reads the head
// of the level it serves, then finishes the pop; a push to the top or round-robin level, a push
// to an empty middle level or a rejected item goes straight to its result; and a push to a
// non-empty middle level walks the middle store, moving each middle entry that must go behind
// the new task one place back before writing the task, over the middle store's single read and
// write port.
module three_level_ready_queue
    import tlrq_pkg::*;
#(
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_cmd  cmd;
    t_stat stat;

    tlrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tlrq_datapath #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in),
        .o_stat  (stat),
        .o_res   (o_out)
    );

endmodule

[tb/sv/three_level_ready_queue_test.sv]
`timescale 1ns / 100ps

module three_level_ready_queue_test;
    import tlrq_pkg::*;

    localparam int DEPTH = LEVEL_DEPTH_DEF;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    three_level_ready_queue u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    typedef struct {
        logic [15:0] id;
        logic [7:0]  prio;
    } t_task;

    t_in   pending_requests[$];
    t_out  expected_replies[$];
    t_task top_tasks[$];
    t_task mid_tasks[$];
    t_task rr_tasks[$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    int  hold_off = 0;
    bit  stim_done = 0;
    bit  hold_requested = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out schedule_request(t_in req);
        t_out  res;
        t_task tk;
        int    pos;
        res = '0;
        tk.id = req.task_id;
        tk.prio = req.task_priority;
        if (req.operation == OP_PUSH) begin
            if (req.task_priority > PRIO_TOP_HIGH) begin
                res.status = ST_RANGE;
            end else if (req.task_priority >= PRIO_TOP_LOW) begin
                res.out_level = LVL_TOP;
                if (top_tasks.size() >= DEPTH) res.status = ST_FULL;
                else top_tasks.push_back(tk);
            end else if (req.task_priority >= PRIO_MID_LOW) begin
                res.out_level = LVL_MID;
                if (mid_tasks.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < mid_tasks.size() &&
                           !(tk.prio > mid_tasks[pos].prio ||
                             (tk.prio == mid_tasks[pos].prio && tk.id < mid_tasks[pos].id)))
                        pos++;
                    mid_tasks.insert(pos, tk);
                end
            end else begin
                res.out_level = LVL_RR;
                if (rr_tasks.size() >= DEPTH) res.status = ST_FULL;
                else rr_tasks.push_back(tk);
            end
        end else begin
            if (top_tasks.size() > 0) begin
                tk = top_tasks.pop_front();
                res.out_level = LVL_TOP;
            end else if (mid_tasks.size() > 0) begin
                tk = mid_tasks.pop_front();
                res.out_level = LVL_MID;
            end else if (rr_tasks.size() > 0) begin
                tk = rr_tasks.pop_front();
                res.out_level = LVL_RR;
            end else begin
                res.status = ST_EMPTY;
                return res;
            end
            res.out_task_id = tk.id;
            res.out_priority = tk.prio;
        end
        return res;
    endfunction

    function automatic t_in make_push(logic [7:0] prio);
        t_in r;
        r.operation = OP_PUSH;
        r.task_id = 16'($urandom);
        r.task_priority = prio;
        return r;
    endfunction

    function automatic t_in make_pop();
        t_in r;
        r.operation = OP_POP;
        r.task_id = 16'($urandom);
        r.task_priority = 8'($urandom);
        return r;
    endfunction

    function automatic logic [7:0] valid_prio();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return 8'($urandom_range(100, 149));
        if (sel < 7) return 8'($urandom_range(50, 55));
        return 8'($urandom_range(0, 49));
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sender: inputs change at the falling edge, transfers are judged at the rising edge.
    int  send_gap = 0;
    bit  in_xfer;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else begin
            if (i_in_valid && in_xfer) begin
                send_gap = gap_length();
            end
            if (!i_in_valid || in_xfer) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 0;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0] === 'x)) begin
                    i_in <= pending_requests.pop_front();
                    i_in_valid <= 1;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    int recv_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (hold_off > 0) begin
            hold_off--;
            i_out_ready <= 0;
        end else if (hold_requested) begin
            hold_requested = 0;
            hold_off = 400;
            i_out_ready <= 0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 0;
        end else begin
            recv_gap = gap_length();
            i_out_ready <= 1;
        end
    end

    t_out want;
    always @(posedge i_clk) begin
        in_xfer = i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (in_xfer) expected_replies.push_back(schedule_request(i_in));
            if (o_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %p", o_out);
                end else begin
                    want = expected_replies.pop_front();
                    if (o_out !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, got %p", want, o_out);
                    end
                end
            end
            if (in_xfer || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_requests.size() > 0 || i_in_valid || expected_replies.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int n;
        int burst;
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_ready = 0;
        i_in = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed part.
        pending_requests.push_back(make_pop());
        begin
            t_in r;
            r = make_push(8'd149); r.task_id = 16'hFFFF; pending_requests.push_back(r);
            r = make_push(8'd100); r.task_id = 16'h0000; pending_requests.push_back(r);
            r = make_push(8'd99);  r.task_id = 16'h0007; pending_requests.push_back(r);
            r = make_push(8'd99);  r.task_id = 16'h0003; pending_requests.push_back(r);
            r = make_push(8'd99);  r.task_id = 16'h0003; pending_requests.push_back(r);
            r = make_push(8'd50);  r.task_id = 16'h0001; pending_requests.push_back(r);
            r = make_push(8'd49);  pending_requests.push_back(r);
            r = make_push(8'd0);   pending_requests.push_back(r);
            r = make_push(8'd150); pending_requests.push_back(r);
            r = make_push(8'd255); pending_requests.push_back(r);
        end
        repeat (9) pending_requests.push_back(make_pop());
        wait_drained();

        // Fill every level past full, then drain past empty.
        for (int lv = 0; lv < 3; lv++)
            for (int k = 0; k < DEPTH + 2; k++)
                pending_requests.push_back(make_push(lv == 0 ? 8'($urandom_range(100, 149)) :
                                                     lv == 1 ? 8'($urandom_range(50, 99)) :
                                                               8'($urandom_range(0, 49))));
        hold_requested = 1;
        repeat (3 * DEPTH + 3) pending_requests.push_back(make_pop());
        wait_drained();

        // Random part: mostly bursts of pushes and pops keeping levels populated.
        n = 0;
        while (n < 1000) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
                if ($urandom_range(0, 19) == 0)
                    pending_requests.push_back(make_push(8'($urandom)));
                else
                    pending_requests.push_back(make_push(valid_prio()));
            end
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) pending_requests.push_back(make_pop());
            n += 12;
            while (pending_requests.size() > 20) @(posedge i_clk);
            if (n > 600 && n < 615) begin
                hold_requested = 1;
                wait_drained();
            end
        end
        wait_drained();
        stim_done = 1;
        repeat (DEPTH + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tlrq_pkg.sv
hw/rtl/tlrq_datapath.sv
hw/rtl/tlrq_ctrl.sv
hw/rtl/three_level_ready_queue.sv
tb/sv/three_level_ready_queue_test.sv
